// ----- sv/tfc_pkg.sv -----
// Package for the temperature focus compensation unit.
// Holds payload and configuration types, register indexes and temperature limits.
// No dependencies.
package tfc_pkg;

  typedef enum logic [2:0] {
    CfgProbePresent   = 3'd0,
    CfgCompEnable     = 3'd1,
    CfgCompDirection  = 3'd2,
    CfgStepCoeff      = 3'd3,
    CfgMaxStep        = 3'd4,
    CfgRefreshPeriod  = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [11:0] TempLow     = -12'sd640;
  localparam logic signed [11:0] TempHigh    = 12'sd1280;
  localparam logic signed [11:0] TempDefault = 12'sd320;
  localparam logic signed [12:0] OneDegree   = 13'sd16;

  localparam logic [15:0] TickMax          = 16'hFFFF;
  localparam logic [31:0] MaxStepReset     = 32'd65535;
  localparam logic [15:0] RefreshReset     = 16'd1500;

  typedef struct packed {
    logic signed [11:0] temp_sample;
    logic [31:0]        target_in;
  } in_t;

  typedef struct packed {
    logic signed [11:0] temperature;
    logic [31:0]        target_out;
    logic               target_moved;
    logic               request_issued;
    logic               reading_taken;
  } out_t;

  typedef struct packed {
    logic        probe_present;
    logic        comp_enable;
    logic        comp_direction;
    logic [15:0] step_coefficient;
    logic [31:0] max_step;
    logic [15:0] refresh_period;
  } cfg_t;

endpackage

// ----- sv/tfc_core.sv -----
// Per-tick compensation datapath and its state registers.
// Computes one result from the transferred tick and the current state; uses tfc_pkg.
module tfc_core import tfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic accept_i,
  input  in_t  in_i,
  output out_t res_o
);

  logic [15:0]        tick_q, tick_d;
  logic               read_q, read_d;
  logic signed [11:0] last_good_q, last_good_d;
  logic signed [11:0] cur_q, cur_d;
  logic signed [11:0] ref_q, ref_d;
  logic               prev_en_q, prev_en_d;
  logic               first_q;

  logic [15:0]        tick_inc;
  logic               prev_en;
  logic               action;
  logic               capture;
  logic               do_read;
  logic               in_range;
  logic signed [11:0] filt;
  logic signed [11:0] ref1;
  logic signed [12:0] diff;
  logic               big;
  logic               fall;
  logic               inward;
  logic               moved;
  logic [32:0]        np;
  logic [32:0]        np_clamped;
  logic [31:0]        target;

  always_comb begin
    prev_en  = first_q ? cfg_i.comp_enable : prev_en_q;
    tick_inc = (tick_q == TickMax) ? tick_q : tick_q + 16'd1;
    action   = cfg_i.probe_present && (tick_inc >= cfg_i.refresh_period);
    tick_d   = action ? 16'd0 : tick_inc;

    in_range = (in_i.temp_sample > TempLow) && (in_i.temp_sample < TempHigh);
    filt     = in_range ? in_i.temp_sample : last_good_q;

    capture  = action && (cfg_i.comp_enable != prev_en) && cfg_i.comp_enable;
    do_read  = action && read_q;
    prev_en_d = action ? cfg_i.comp_enable : prev_en;
    read_d    = action ? ~read_q : read_q;

    last_good_d = ((capture || do_read) && in_range) ? in_i.temp_sample : last_good_q;
    ref1  = capture ? filt : ref_q;
    cur_d = do_read ? filt : cur_q;

    diff   = $signed({ref1[11], ref1}) - $signed({cur_d[11], cur_d});
    big    = (diff >= OneDegree) || (diff <= -OneDegree);
    fall   = cur_d < ref1;
    inward = cfg_i.comp_direction ? !fall : fall;

    if (inward) begin
      np = (in_i.target_in >= 32'(cfg_i.step_coefficient))
         ? {1'b0, in_i.target_in - 32'(cfg_i.step_coefficient)} : 33'd0;
    end else begin
      np = {1'b0, in_i.target_in} + 33'(cfg_i.step_coefficient);
    end
    np_clamped = (np > {1'b0, cfg_i.max_step}) ? {1'b0, cfg_i.max_step} : np;

    moved  = action && cfg_i.comp_enable && big;
    target = moved ? np_clamped[31:0] : in_i.target_in;
    ref_d  = moved ? cur_d : ref1;

    res_o.temperature    = last_good_d;
    res_o.target_out     = target;
    res_o.target_moved   = moved;
    res_o.request_issued = action && !read_q;
    res_o.reading_taken  = capture || do_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      read_q      <= 1'b0;
      last_good_q <= TempDefault;
      cur_q       <= '0;
      ref_q       <= '0;
      prev_en_q   <= 1'b0;
      first_q     <= 1'b1;
    end else if (accept_i) begin
      tick_q      <= tick_d;
      read_q      <= read_d;
      last_good_q <= last_good_d;
      cur_q       <= cur_d;
      ref_q       <= ref_d;
      prev_en_q   <= prev_en_d;
      first_q     <= 1'b0;
    end
  end

endmodule

// ----- sv/temperature_focus_compensation_unit.sv -----
// Top level: the result of each accepted tick is registered in the output stage.
// Throughput one tick per cycle unless in_stall_o is high; a two-entry output stage
// (result and skid register) keeps taking ticks while one result waits downstream.
// Reset clears tick count, phase and handshake state, loads last good temperature
// with twenty degrees and the configuration registers with their defaults.
// Uses tfc_pkg and tfc_core.
module temperature_focus_compensation_unit import tfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  cfg_t cfg_q;
  out_t res;
  out_t out_q;
  out_t skid_q;
  logic out_valid_q;
  logic skid_valid_q;
  logic accept;
  logic out_free;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_present    <= 1'b0;
      cfg_q.comp_enable      <= 1'b0;
      cfg_q.comp_direction   <= 1'b0;
      cfg_q.step_coefficient <= '0;
      cfg_q.max_step         <= MaxStepReset;
      cfg_q.refresh_period   <= RefreshReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgProbePresent:  cfg_q.probe_present    <= cfg_data_i[0];
        CfgCompEnable:    cfg_q.comp_enable      <= cfg_data_i[0];
        CfgCompDirection: cfg_q.comp_direction   <= cfg_data_i[0];
        CfgStepCoeff:     cfg_q.step_coefficient <= cfg_data_i[15:0];
        CfgMaxStep:       cfg_q.max_step         <= cfg_data_i[31:0];
        CfgRefreshPeriod: cfg_q.refresh_period   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  tfc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .in_i     (in_data_i),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/sv/temperature_focus_compensation_unit_tb.sv -----
// Testbench for the temperature focus compensation unit: directed and random ticks,
// with results checked against an in-bench prediction of each tick.
// Depends on tfc_pkg and temperature_focus_compensation_unit.
module temperature_focus_compensation_unit_tb;
  import tfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      cfg_we    = 1'b0;
  cfg_idx_e  cfg_idx   = CfgProbePresent;
  logic [31:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  in_t       in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_t      out_data;

  temperature_focus_compensation_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predicted state of the unit
  cfg_t        model_cfg;
  logic [15:0] tick_cnt;
  logic        rd_phase;
  int          good_temp;
  int          cur_temp;
  int          ref_temp;
  logic        en_prev;
  logic        first_tick;

  out_t        predicted_q[$];
  int          mismatch_cnt = 0;
  logic [31:0] last_target = '0;
  int          drift_temp = 320;

  logic        gaps_on = 1'b1;
  int          burst_left = 0;
  logic        quiet = 1'b0;
  logic        hold_go = 1'b0;
  int          hold_len = 0;

  function automatic int screen_sample(int s);
    if (s > int'(TempLow) && s < int'(TempHigh)) begin
      good_temp = s;
    end
    return good_temp;
  endfunction

  function automatic out_t compensate_tick(in_t t);
    out_t   r;
    int     s;
    int     diff;
    longint tgt;
    longint np;
    logic   fall;
    logic   inward;
    s = t.temp_sample;
    tgt = t.target_in;
    r = '0;
    if (first_tick) begin
      en_prev = model_cfg.comp_enable;
      first_tick = 1'b0;
    end
    if (tick_cnt != 16'hFFFF) tick_cnt++;
    if (model_cfg.probe_present && tick_cnt >= model_cfg.refresh_period) begin
      tick_cnt = '0;
      if (model_cfg.comp_enable != en_prev) begin
        en_prev = model_cfg.comp_enable;
        if (en_prev) begin
          ref_temp = screen_sample(s);
          r.reading_taken = 1'b1;
        end
      end
      if (rd_phase) begin
        cur_temp = screen_sample(s);
        r.reading_taken = 1'b1;
      end else begin
        r.request_issued = 1'b1;
      end
      rd_phase = !rd_phase;
      if (model_cfg.comp_enable) begin
        diff = ref_temp - cur_temp;
        if (diff < 0) diff = -diff;
        if (diff >= 16) begin
          fall = cur_temp < ref_temp;
          inward = model_cfg.comp_direction ? !fall : fall;
          if (inward) begin
            np = (tgt >= model_cfg.step_coefficient) ? tgt - model_cfg.step_coefficient : 0;
          end else begin
            np = tgt + model_cfg.step_coefficient;
          end
          if (np > model_cfg.max_step) np = model_cfg.max_step;
          tgt = np;
          r.target_moved = 1'b1;
          ref_temp = cur_temp;
        end
      end
    end
    r.temperature = good_temp[11:0];
    r.target_out = tgt[31:0];
    return r;
  endfunction

  function automatic in_t mk_tick(int s, logic [31:0] t);
    in_t r;
    r.temp_sample = s[11:0];
    r.target_in = t;
    return r;
  endfunction

  function automatic in_t random_tick();
    int          step;
    int          s;
    logic [31:0] t;
    step = $urandom_range(0, 40);
    drift_temp += step - 20;
    if (drift_temp < -600) drift_temp = -600;
    if (drift_temp > 1240) drift_temp = 1240;
    case ($urandom_range(0, 15))
      0: s = $urandom;
      1: s = $urandom_range(0, 1) ? -640 - int'($urandom_range(0, 1408))
                                  : 1280 + int'($urandom_range(0, 767));
      default: begin
        step = $urandom_range(0, 12);
        s = drift_temp + step - 6;
      end
    endcase
    case ($urandom_range(0, 7))
      0: t = $urandom;
      1: t = $urandom_range(0, 200);
      2: t = 32'hFFFF_FFFF - $urandom_range(0, 200);
      default: t = last_target;
    endcase
    return mk_tick(s, t);
  endfunction

  task automatic send_tick(in_t item);
    out_t want;
    int   gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (in_stall);
    want = compensate_tick(item);
    predicted_q.push_back(want);
    last_target = want.target_out;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [31:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgProbePresent:  model_cfg.probe_present = val[0];
      CfgCompEnable:    model_cfg.comp_enable = val[0];
      CfgCompDirection: model_cfg.comp_direction = val[0];
      CfgStepCoeff:     model_cfg.step_coefficient = val[15:0];
      CfgMaxStep:       model_cfg.max_step = val;
      CfgRefreshPeriod: model_cfg.refresh_period = val[15:0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("mismatch in %s: expected %h, got %h", name, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (predicted_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("result with nothing pending: %h", out_data);
      end else begin
        want = predicted_q.pop_front();
        check_field("temperature", want.temperature, out_data.temperature);
        check_field("target_out", want.target_out, out_data.target_out);
        check_field("target_moved", want.target_moved, out_data.target_moved);
        check_field("request_issued", want.request_issued, out_data.request_issued);
        check_field("reading_taken", want.reading_taken, out_data.reading_taken);
      end
    end
  end

  initial begin : rx_pattern
    int   run_left;
    int   hold_left;
    logic level;
    logic nxt;
    run_left = 0;
    hold_left = 0;
    level = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_left = hold_len;
        hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        nxt = 1'b1;
        hold_left--;
      end else if (quiet) begin
        nxt = 1'b0;
      end else begin
        if (run_left == 0) begin
          level = !level;
          if (level) begin
            run_left = $urandom_range(1, 6);
          end else begin
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          end
        end
        run_left--;
        nxt = level;
      end
      out_stall <= nxt;
    end
  end

  task automatic test_first_tick();
    set_reg(CfgCompEnable, 32'd1);
    repeat (3) send_tick(mk_tick(400, 32'd1000));
    set_reg(CfgProbePresent, 32'd1);
    set_reg(CfgRefreshPeriod, 32'd1);
    set_reg(CfgStepCoeff, 32'd5);
    send_tick(mk_tick(400, 32'd1000));
    send_tick(mk_tick(400, 32'd1000));
    send_tick(mk_tick(600, 32'd1000));
    send_tick(mk_tick(600, 32'd1000));
  endtask

  task automatic test_directed();
    int samples[6] = '{-2048, -640, -639, 2047, 1280, 1279};
    set_reg(CfgCompEnable, 32'd0);
    set_reg(CfgCompDirection, 32'd0);
    set_reg(CfgStepCoeff, 32'd100);
    set_reg(CfgMaxStep, 32'hFFFF_FFFF);
    foreach (samples[i]) begin
      if (!rd_phase) send_tick(mk_tick(0, 32'hFFFF_FFFF));
      send_tick(mk_tick(samples[i], i[0] ? 32'hFFFF_FFFF : 32'd0));
    end
    set_reg(CfgCompEnable, 32'd1);
    send_tick(mk_tick(320, 32'hFFFF_FFF0));
    send_tick(mk_tick(360, 32'hFFFF_FFF0));
    send_tick(mk_tick(360, 32'hFFFF_FFF0));
    send_tick(mk_tick(100, 32'd50));
    send_tick(mk_tick(100, 32'd50));
    send_tick(mk_tick(115, 32'd7));
    send_tick(mk_tick(115, 32'd7));
    send_tick(mk_tick(116, 32'd7));
    send_tick(mk_tick(116, 32'd7));
    set_reg(CfgCompDirection, 32'd1);
    set_reg(CfgStepCoeff, 32'd65535);
    set_reg(CfgMaxStep, 32'd0);
    set_reg(CfgRefreshPeriod, 32'd0);
    send_tick(mk_tick(500, 32'd123));
    send_tick(mk_tick(500, 32'd123));
    send_tick(mk_tick(200, 32'd9));
    send_tick(mk_tick(200, 32'd9));
  endtask

  task automatic test_random();
    logic [31:0] val;
    for (int p = 0; p < 8; p++) begin
      set_reg(CfgProbePresent, 32'($urandom_range(0, 7) != 0));
      set_reg(CfgCompEnable, 32'($urandom_range(0, 3) != 0));
      set_reg(CfgCompDirection, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: val = 32'd0;
        1: val = 32'd65535;
        2: val = $urandom_range(0, 65535);
        default: val = $urandom_range(1, 300);
      endcase
      set_reg(CfgStepCoeff, val);
      case ($urandom_range(0, 5))
        0: val = 32'd0;
        1: val = 32'hFFFF_FFFF;
        2: val = $urandom;
        default: val = $urandom_range(1000, 100000);
      endcase
      set_reg(CfgMaxStep, val);
      case ($urandom_range(0, 3))
        0: val = 32'd1;
        1: val = $urandom_range(2, 6);
        2: val = $urandom_range(7, 40);
        default: val = $urandom_range(1, 2);
      endcase
      set_reg(CfgRefreshPeriod, val);
      repeat (170) send_tick(random_tick());
    end
  endtask

  task automatic test_backpressure();
    set_reg(CfgProbePresent, 32'd1);
    set_reg(CfgCompEnable, 32'd1);
    set_reg(CfgRefreshPeriod, 32'd1);
    set_reg(CfgStepCoeff, 32'd37);
    set_reg(CfgMaxStep, 32'hFFFF_FFFF);
    hold_len = 60;
    hold_go = 1'b1;
    repeat (80) send_tick(random_tick());
  endtask

  task automatic test_drain_pause();
    repeat (20) send_tick(random_tick());
    wait_idle();
    repeat (20) send_tick(random_tick());
  endtask

  task automatic test_probe_absent();
    set_reg(CfgProbePresent, 32'd0);
    set_reg(CfgRefreshPeriod, 32'd30);
    gaps_on = 1'b0;
    quiet = 1'b1;
    repeat (40) send_tick(random_tick());
    set_reg(CfgProbePresent, 32'd1);
    repeat (6) send_tick(random_tick());
    gaps_on = 1'b1;
    quiet = 1'b0;
  endtask

  initial begin
    model_cfg = '{probe_present: 1'b0, comp_enable: 1'b0, comp_direction: 1'b0,
                  step_coefficient: 16'd0, max_step: MaxStepReset,
                  refresh_period: RefreshReset};
    tick_cnt = '0;
    rd_phase = 1'b0;
    good_temp = TempDefault;
    cur_temp = 0;
    ref_temp = 0;
    en_prev = 1'b0;
    first_tick = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_first_tick();
    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_probe_absent();
    wait_idle();
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("temperature_focus_compensation_unit_tb: done, clean");
    end else begin
      $display("temperature_focus_compensation_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("temperature_focus_compensation_unit_tb: done, errors");
    $finish;
  end

endmodule
